FILE: rtl/thrmix_pkg.sv
// Shared constants, coefficient ROM and pipeline control types of the thrust mixer.
`default_nettype none

package thrmix_pkg;

	// Field geometry
	localparam int AXES     = 6;
	localparam int NUM_ROWS = 8;
	localparam int AXIS_W   = 16;
	localparam int SPEED_W  = 8;

	// Defaults for the top-level parameters
	localparam int NUM_THRUSTERS_DEF  = 8;
	localparam int COEF_FRAC_BITS_DEF = 14;

	// Divide-by-255 window: at or above this integer value the speed saturates at 127
	localparam int DIV_LIM  = 32640;
	localparam int DIV_IN_W = 15;
	localparam logic [6:0] SPEED_MAX = 7'd127;

	// Decimal coefficients in units of 1e-8, axis order march, lag, depth, yaw, roll, pitch
	localparam longint DEC_SCALE = 64'd100000000;
	localparam longint COEF_DEC [NUM_ROWS][AXES] = '{
		'{-20411490, -25000000,  35350677,  100000000,  100000000, -618060},
		'{-20411490,  25000000,  35350670, -100000000, -100000000, -618060},
		'{ 20411490, -25000000,  35350670, -100000000, -100000000, -618060},
		'{ 20411490,  25000000,  35350677,  100000000,  100000000, -618060},
		'{-20411496, -25000000, -35350677,  100000000,  100000000, -618060},
		'{-20411496,  25000000, -35350670, -100000000, -100000000, -618060},
		'{ 20411490,  25000000, -35350677,  100000000,  100000000,  618065},
		'{ 20411496, -25000000, -35350670, -100000000, -100000000, -618060}
	};

	// Rows whose weighted sum is negated (thrusters 0 and 5)
	localparam logic [NUM_ROWS-1:0] ROW_NEG = 8'b0010_0001;

	// Pipeline advance strobes handed to each thruster row
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
	} thrmix_adv_t;

	// Round a decimal coefficient to the fixed-point grid, ties away from zero
	function automatic longint coef_fixed(input int row, input int axis, input int frac);
		longint d;
		longint mag;
		longint q;
		d   = COEF_DEC[row][axis];
		mag = (d < 0) ? -d : d;
		q   = (mag * (longint'(1) << frac) + DEC_SCALE / 2) / DEC_SCALE;
		return (d < 0) ? -q : q;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/thrmix_scale.sv
// Scale a row sum to a thruster speed: truncate, divide by 255, clamp to +/-127.
`default_nettype none

module thrmix_scale #(
	parameter int SUM_W          = 37,
	parameter int COEF_FRAC_BITS = thrmix_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic signed [SUM_W-1:0]                 sum,
	output logic signed [thrmix_pkg::SPEED_W-1:0]   speed
);
	import thrmix_pkg::*;

	localparam int SH_W = SUM_W - COEF_FRAC_BITS;

	logic             neg;
	logic [SUM_W-1:0] mag;
	logic [SH_W-1:0]  whole;
	logic [DIV_IN_W-1:0] x;
	logic [15:0]      acc;
	logic             sat;
	logic [6:0]       q;

	// Take magnitude, drop fraction bits (toward zero)
	assign neg   = sum[SUM_W-1];
	assign mag   = neg ? SUM_W'(-sum) : SUM_W'(sum);
	assign whole = mag[SUM_W-1:COEF_FRAC_BITS];

	// x / 255 == (x + (x >> 8) + 1) >> 8 for x below 2^16 - 1
	assign x   = whole[DIV_IN_W-1:0];
	assign acc = 16'(x) + 16'(x >> 8) + 16'd1;
	assign sat = (whole >= SH_W'(DIV_LIM));
	assign q   = sat ? SPEED_MAX : acc[14:8];

	// Restore sign
	assign speed = neg ? -SPEED_W'(q) : SPEED_W'(q);

endmodule

`default_nettype wire

FILE: rtl/thrmix_row.sv
// One thruster row: six coefficient products, row sum with sign, and scaling.
`default_nettype none

module thrmix_row #(
	parameter int ROW            = 0,
	parameter int COEF_FRAC_BITS = thrmix_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                      clk,
	input  thrmix_pkg::thrmix_adv_t                   adv,
	input  logic signed [thrmix_pkg::AXIS_W-1:0]      axis_s1 [thrmix_pkg::AXES],
	output logic signed [thrmix_pkg::SPEED_W-1:0]     speed
);
	import thrmix_pkg::*;

	localparam int   COEF_W = COEF_FRAC_BITS + 2;
	localparam int   PROD_W = AXIS_W + COEF_W;
	localparam int   SUM_W  = PROD_W + 3;
	localparam logic NEG    = ROW_NEG[ROW];

	logic signed [PROD_W-1:0] prod_s2 [AXES];
	logic signed [SUM_W-1:0]  sum_c;
	logic signed [SUM_W-1:0]  sum_s3;

	// Multiply each selected axis by its ROM coefficient
	for (genvar a = 0; a < AXES; a++) begin : g_mul
		localparam logic signed [COEF_W-1:0] COEF =
			COEF_W'(coef_fixed(ROW, a, COEF_FRAC_BITS));
		always_ff @(posedge clk) begin
			if (adv.ld_s2) begin
				prod_s2[a] <= PROD_W'(axis_s1[a]) * PROD_W'(COEF);
			end
		end
	end

	// Add the six products, negate on flagged rows
	always_comb begin
		sum_c = '0;
		for (int a = 0; a < AXES; a++) begin
			sum_c = sum_c + SUM_W'(prod_s2[a]);
		end
		if (NEG) begin
			sum_c = -sum_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s3) begin
			sum_s3 <= sum_c;
		end
	end

	thrmix_scale #(
		.SUM_W          (SUM_W),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_scale (
		.sum   (sum_s3),
		.speed (speed)
	);

endmodule

`default_nettype wire

FILE: rtl/thrust_allocation_mixer.sv
// Top level of the thrust mixer: source select, row pipeline, output register.
//
//  channel   direction  handshake           beat
//  cfg       in         cfg_valid/ready     axis_source_mask (cfg_data)
//  in        in         in_valid/in_stall   joy_* and stabil_* axis commands
//  out       out        out_valid/out_stall speed_* thruster commands
//
// Four register stages: axis select, products, row sum, scaled speeds.
// One beat per cycle is sustained while out_stall is low.
// Reset clears the mask and all valid flags; payload registers are not reset.
// A stall on the output fills the stages behind it; in_stall rises only when all
// four stages hold a beat. cfg_ready is always high.
`default_nettype none

module thrust_allocation_mixer #(
	parameter int NUM_THRUSTERS  = thrmix_pkg::NUM_THRUSTERS_DEF,
	parameter int COEF_FRAC_BITS = thrmix_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [15:0] joy_march,
	input  logic signed [15:0] joy_lag,
	input  logic signed [15:0] joy_depth,
	input  logic signed [15:0] joy_yaw,
	input  logic signed [15:0] joy_roll,
	input  logic signed [15:0] joy_pitch,
	input  logic signed [15:0] stabil_march,
	input  logic signed [15:0] stabil_lag,
	input  logic signed [15:0] stabil_depth,
	input  logic signed [15:0] stabil_yaw,
	input  logic signed [15:0] stabil_roll,
	input  logic signed [15:0] stabil_pitch,

	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [7:0] speed_fdr,
	output logic signed [7:0] speed_fdl,
	output logic signed [7:0] speed_bdr,
	output logic signed [7:0] speed_bdl,
	output logic signed [7:0] speed_fur,
	output logic signed [7:0] speed_ful,
	output logic signed [7:0] speed_bur,
	output logic signed [7:0] speed_bul
);
	import thrmix_pkg::*;

	logic [AXES-1:0]            mask_q;
	logic signed [AXIS_W-1:0]   joy  [AXES];
	logic signed [AXIS_W-1:0]   stab [AXES];
	logic signed [AXIS_W-1:0]   axis_s1 [AXES];
	logic signed [SPEED_W-1:0]  speed_c [NUM_ROWS];
	logic signed [SPEED_W-1:0]  speed_q [NUM_ROWS];

	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic free_s1, free_s2, free_s3, free_out;
	logic ld_s1, ld_out;
	thrmix_adv_t adv;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			mask_q <= cfg_data;
		end
	end

	// Stage occupancy and advance
	assign free_out = !out_valid_q || !out_stall;
	assign free_s3  = !valid_s3 || free_out;
	assign free_s2  = !valid_s2 || free_s3;
	assign free_s1  = !valid_s1 || free_s2;
	assign in_stall = !free_s1;

	assign ld_s1      = in_valid && free_s1;
	assign adv.ld_s2  = valid_s1 && free_s2;
	assign adv.ld_s3  = valid_s2 && free_s3;
	assign ld_out     = valid_s3 && free_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (free_s1)  valid_s1    <= in_valid;
			if (free_s2)  valid_s2    <= valid_s1;
			if (free_s3)  valid_s3    <= valid_s2;
			if (free_out) out_valid_q <= valid_s3;
		end
	end

	// Gather axis fields in mask bit order
	assign joy[0]  = joy_march;
	assign joy[1]  = joy_lag;
	assign joy[2]  = joy_depth;
	assign joy[3]  = joy_yaw;
	assign joy[4]  = joy_roll;
	assign joy[5]  = joy_pitch;
	assign stab[0] = stabil_march;
	assign stab[1] = stabil_lag;
	assign stab[2] = stabil_depth;
	assign stab[3] = stabil_yaw;
	assign stab[4] = stabil_roll;
	assign stab[5] = stabil_pitch;

	// Pick stabilizer or joystick per axis
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			for (int a = 0; a < AXES; a++) begin
				axis_s1[a] <= mask_q[a] ? stab[a] : joy[a];
			end
		end
	end

	// Thruster rows; rows past the fitted count read zero
	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
		if (r < NUM_THRUSTERS) begin : g_used
			thrmix_row #(
				.ROW            (r),
				.COEF_FRAC_BITS (COEF_FRAC_BITS)
			) u_row (
				.clk     (clk),
				.adv     (adv),
				.axis_s1 (axis_s1),
				.speed   (speed_c[r])
			);
		end else begin : g_unused
			assign speed_c[r] = '0;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (ld_out) begin
			for (int r = 0; r < NUM_ROWS; r++) begin
				speed_q[r] <= speed_c[r];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign speed_fdr = speed_q[0];
	assign speed_fdl = speed_q[1];
	assign speed_bdr = speed_q[2];
	assign speed_bdl = speed_q[3];
	assign speed_fur = speed_q[4];
	assign speed_ful = speed_q[5];
	assign speed_bur = speed_q[6];
	assign speed_bul = speed_q[7];

endmodule

`default_nettype wire

FILE: rtl/thrmix_checker.sv
// Port-level checks for the thrust mixer, bound to the top level.
`default_nettype none

module thrmix_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic signed [7:0] speed_fdr,
	input logic signed [7:0] speed_fdl,
	input logic signed [7:0] speed_bdr,
	input logic signed [7:0] speed_bdl,
	input logic signed [7:0] speed_fur,
	input logic signed [7:0] speed_ful,
	input logic signed [7:0] speed_bur,
	input logic signed [7:0] speed_bul
);

	// A stalled output beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out beat dropped under stall");

	// A stalled output beat keeps its speeds
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(speed_fdr) && $stable(speed_fdl)
			&& $stable(speed_bdr) && $stable(speed_bdl) && $stable(speed_fur)
			&& $stable(speed_ful) && $stable(speed_bur) && $stable(speed_bul))
		else $error("out beat changed under stall");

	// Input back-pressure only comes from a stalled, occupied output
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall without output back-pressure");

	// Clamp never lets a speed reach -128
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> speed_fdr != 8'h80 && speed_fdl != 8'h80 && speed_bdr != 8'h80
			&& speed_bdl != 8'h80 && speed_fur != 8'h80 && speed_ful != 8'h80
			&& speed_bur != 8'h80 && speed_bul != 8'h80)
		else $error("speed outside +/-127");

endmodule

bind thrust_allocation_mixer thrmix_checker u_thrmix_checker (.*);

`default_nettype wire
